[design/dsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants of the 3D diffusion stencil
// Grid size, delay line geometry, the job record passed from front to back,
// the weight set and the configuration register indexes.
// ----------------------------------------------------------------------------
package dsd_pkg;

  // Grid size in cells.
  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;

  localparam int PLANE_CELLS = GRID_X * GRID_Y;

  // The delay line is built from two long and two short RAM delays plus two registers.
  localparam int LONG_DEPTH  = PLANE_CELLS - GRID_X - 1;
  localparam int SHORT_DEPTH = GRID_X - 2;
  localparam int LONG_AW     = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
  localparam int SHORT_AW    = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;

  // Coordinate and fill counter widths.
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int ZW = $clog2(GRID_Z);
  localparam int IW = $clog2(PLANE_CELLS + 1);

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int VW = 32;

  // Operands of one stencil evaluation, edge substitution already applied.
  typedef struct packed {
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] e;
    logic signed [VW-1:0] w;
    logic signed [VW-1:0] n;
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] t;
    logic signed [VW-1:0] b;
    logic                 last;
  } job_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [VW-1:0] east;
    logic signed [VW-1:0] west;
    logic signed [VW-1:0] north;
    logic signed [VW-1:0] south;
    logic signed [VW-1:0] top;
    logic signed [VW-1:0] bottom;
    logic signed [VW-1:0] centre;
  } weights_t;

  typedef enum logic [2:0] {
    CFG_EAST   = 3'd0,
    CFG_WEST   = 3'd1,
    CFG_NORTH  = 3'd2,
    CFG_SOUTH  = 3'd3,
    CFG_TOP    = 3'd4,
    CFG_BOTTOM = 3'd5,
    CFG_CENTRE = 3'd6
  } cfg_idx_t;

  localparam logic signed [VW-1:0] CENTRE_RESET = 32'sh4000_0000;

endpackage
`default_nettype wire

[design/dsd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_ram: generic single-port RAM
// One address per cycle; the old word is read before the write and registered.
// ----------------------------------------------------------------------------
module dsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write access.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata      <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

endmodule
`default_nettype wire

[design/dsd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_front: request intake, plane delay line and neighbor selection
// Keeps two planes of history, tracks the output coordinate and builds one
// job per request once the first plane has gone by.
// ----------------------------------------------------------------------------
module dsd_front
  import dsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_cell_value,
  input  wire q_stat_t     q_stat,
  output logic             push,
  output job_t             job
);

  logic            accept;
  logic [VW-1:0]   value;
  logic            emit;
  logic            x_last, y_last, z_last, grid_last;

  logic [IW-1:0]   seen_r, seen_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [ZW-1:0]   z_r, z_nxt;
  logic [LONG_AW-1:0]  lptr_r, lptr_nxt;
  logic [SHORT_AW-1:0] sptr_r, sptr_nxt;

  // Delay line taps, named by age in requests.
  logic [VW-1:0]   t_pmx, t_pm1, t_ppx, t_2p;
  logic [VW-1:0]   t_p_r, t_pp1_r;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  // Flush requests store zero.
  assign value    = in_op ? '0 : in_cell_value;
  assign emit     = (seen_r == IW'(PLANE_CELLS));

  assign x_last    = (x_r == XW'(GRID_X - 1));
  assign y_last    = (y_r == YW'(GRID_Y - 1));
  assign z_last    = (z_r == ZW'(GRID_Z - 1));
  assign grid_last = x_last && y_last && z_last;

  // Delay line: long, short, two registers, short, long.
  dsd_ram #(.WIDTH(VW), .DEPTH(LONG_DEPTH)) u_ram_a (
    .clk(clk), .en(accept), .addr(lptr_r), .wdata(value), .rdata(t_pmx)
  );
  dsd_ram #(.WIDTH(VW), .DEPTH(SHORT_DEPTH)) u_ram_b (
    .clk(clk), .en(accept), .addr(sptr_r), .wdata(t_pmx), .rdata(t_pm1)
  );
  dsd_ram #(.WIDTH(VW), .DEPTH(SHORT_DEPTH)) u_ram_c (
    .clk(clk), .en(accept), .addr(sptr_r), .wdata(t_pp1_r), .rdata(t_ppx)
  );
  dsd_ram #(.WIDTH(VW), .DEPTH(LONG_DEPTH)) u_ram_d (
    .clk(clk), .en(accept), .addr(lptr_r), .wdata(t_ppx), .rdata(t_2p)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      t_p_r   <= t_pm1;
      t_pp1_r <= t_p_r;
    end
  end

  // Circular pointers of the RAM delays.
  always_comb begin
    lptr_nxt = lptr_r;
    sptr_nxt = sptr_r;
    if (accept) begin
      lptr_nxt = (lptr_r == LONG_AW'(LONG_DEPTH - 1)) ? '0 : lptr_r + 1'b1;
      sptr_nxt = (sptr_r == SHORT_AW'(SHORT_DEPTH - 1)) ? '0 : sptr_r + 1'b1;
    end
  end

  // Fill count and output coordinate.
  always_comb begin
    seen_nxt = seen_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (accept) begin
      if (!emit) begin
        seen_nxt = seen_r + 1'b1;
      end else if (grid_last) begin
        seen_nxt = '0;
        x_nxt    = '0;
        y_nxt    = '0;
        z_nxt    = '0;
      end else if (!x_last) begin
        x_nxt = x_r + 1'b1;
      end else begin
        x_nxt = '0;
        if (!y_last) begin
          y_nxt = y_r + 1'b1;
        end else begin
          y_nxt = '0;
          z_nxt = z_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lptr_r <= '0;
      sptr_r <= '0;
      seen_r <= '0;
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
    end else begin
      lptr_r <= lptr_nxt;
      sptr_r <= sptr_nxt;
      seen_r <= seen_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  // Neighbor selection; an off-grid neighbor takes the centre value.
  assign push = accept && emit;
  always_comb begin
    job.c    = t_p_r;
    job.e    = x_last ? t_p_r : t_pm1;
    job.w    = (x_r == '0) ? t_p_r : t_pp1_r;
    job.s    = y_last ? t_p_r : t_pmx;
    job.n    = (y_r == '0) ? t_p_r : t_ppx;
    job.t    = z_last ? t_p_r : value;
    job.b    = (z_r == '0) ? t_p_r : t_2p;
    job.last = grid_last;
  end

endmodule
`default_nettype wire

[design/dsd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_queue: short job FIFO between front and back
// Lets the intake keep taking requests while the arithmetic is stalled.
// ----------------------------------------------------------------------------
module dsd_queue
  import dsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  job_t           slots [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign head       = slots[rd_r];
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_r] <= push_job;
    end
  end

  // Pointer and occupancy update.
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[design/dsd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_back: weighted sum, rounding and saturation
// Seven parallel products, a registered adder tree, then round to nearest
// and clamp into the output register.
// ----------------------------------------------------------------------------
module dsd_back
  import dsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire weights_t wts,
  input  wire job_t     head,
  input  wire q_stat_t  q_stat,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output logic [31:0]   out_value,
  output logic          out_last_cell
);

  logic advance;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               l1_r, l2_r, l3_r, l4_r;
  logic signed [63:0] p_r [7];
  logic signed [64:0] a_r [4];
  logic signed [65:0] b_r [2];
  logic signed [66:0] sum_r;
  logic signed [36:0] shifted;
  logic [31:0]        sat;

  // The whole pipeline holds while a result waits at the output.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_stat.empty;

  // Stage 1: products.
  always_ff @(posedge clk) begin
    if (advance) begin
      p_r[0] <= wts.centre * head.c;
      p_r[1] <= wts.west   * head.w;
      p_r[2] <= wts.east   * head.e;
      p_r[3] <= wts.south  * head.s;
      p_r[4] <= wts.north  * head.n;
      p_r[5] <= wts.bottom * head.b;
      p_r[6] <= wts.top    * head.t;
      l1_r   <= head.last;
    end
  end

  // Stages 2 to 4: adder tree; the rounding half rides in with the last product.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_r[0] <= {p_r[0][63], p_r[0]} + {p_r[1][63], p_r[1]};
      a_r[1] <= {p_r[2][63], p_r[2]} + {p_r[3][63], p_r[3]};
      a_r[2] <= {p_r[4][63], p_r[4]} + {p_r[5][63], p_r[5]};
      a_r[3] <= {p_r[6][63], p_r[6]} + 65'sh2000_0000;
      b_r[0] <= {a_r[0][64], a_r[0]} + {a_r[1][64], a_r[1]};
      b_r[1] <= {a_r[2][64], a_r[2]} + {a_r[3][64], a_r[3]};
      sum_r  <= {b_r[0][65], b_r[0]} + {b_r[1][65], b_r[1]};
      l2_r   <= l1_r;
      l3_r   <= l2_r;
      l4_r   <= l3_r;
    end
  end

  // Scale back to Q2.30 and clamp to the 32-bit range.
  assign shifted = sum_r[66:30];
  always_comb begin
    if (shifted[36:31] == '0 || shifted[36:31] == '1) begin
      sat = shifted[31:0];
    end else if (shifted[36]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value     <= sat;
      out_last_cell <= l4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1_r      <= !q_stat.empty;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_valid <= v4_r;
    end
  end

endmodule
`default_nettype wire

[design/diffusion_stencil_3d.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diffusion_stencil_3d: one time step of a seven-point 3D diffusion stencil
// Cells stream in raster order through a two-plane delay line; each request
// after the first plane yields the weighted, rounded, saturated update of
// the cell one plane behind it.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    in_op, in_cell_value
//   out      output     out_valid/out_stall  out_value, out_last_cell
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One request per cycle is taken while in_stall is low.
// Rate is set by one write and one read per cycle on each delay line RAM.
// Reset is synchronous and clears counters, pointers and pipeline valid bits.
// An output stall holds the arithmetic pipeline; the four-entry job queue
// then absorbs requests until it fills and in_stall rises.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d
  import dsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_cell_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  output logic             out_last_cell,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  weights_t wts_r, wts_nxt;
  q_stat_t  q_stat;
  job_t     push_job, head;
  logic     push, pop;

  // Weight registers.
  always_comb begin
    wts_nxt = wts_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EAST:   wts_nxt.east   = cfg_wdata;
        CFG_WEST:   wts_nxt.west   = cfg_wdata;
        CFG_NORTH:  wts_nxt.north  = cfg_wdata;
        CFG_SOUTH:  wts_nxt.south  = cfg_wdata;
        CFG_TOP:    wts_nxt.top    = cfg_wdata;
        CFG_BOTTOM: wts_nxt.bottom = cfg_wdata;
        CFG_CENTRE: wts_nxt.centre = cfg_wdata;
        default:    wts_nxt = wts_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wts_r <= '{east: '0, west: '0, north: '0, south: '0, top: '0, bottom: '0,
                 centre: CENTRE_RESET};
    end else begin
      wts_r <= wts_nxt;
    end
  end

  dsd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_cell_value(in_cell_value),
    .q_stat(q_stat), .push(push), .job(push_job)
  );

  dsd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_job(push_job),
    .pop(pop), .head(head), .stat(q_stat)
  );

  dsd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .wts(wts_r), .head(head), .q_stat(q_stat), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_last_cell(out_last_cell)
  );

`ifndef SYNTHESIS
  // No job leaves the queue while a finished result is held at the output.
  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !pop)
    else $error("job popped while output held");

  // The front never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // Nothing is popped from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[test/diffusion_stencil_3d_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_stencil_3d_test: self-checking bench for the 3D diffusion stencil
// Streams the lead-in plane of a 64x64x64 grid and then about nine hundred
// requests whose results are checked. Requests cover the extreme values and
// flush requests out of place. The weights are reloaded at phase boundaries,
// and both handshakes idle at varied rates. A scoreboard keeps its own copy
// of the delay line and predicts every result in order.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d_test;
  import dsd_pkg::*;

  localparam int LINE_WORDS  = 2 * PLANE_CELLS + 1;
  localparam int CHECK_ITEMS = 900;
  localparam int PHASE_LEN   = 225;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } cell_result_t;

  // Predicts stencil updates from accepted requests and checks the results.
  class stencil_scoreboard;
    logic [31:0]          line [LINE_WORDS];
    int unsigned          wpos, seen, ox, oy, oz;
    logic signed [31:0]   wt [7];
    cell_result_t         pending [$];
    int                   errors, checked;

    function void clear();
      foreach (line[i]) line[i] = '0;
      wpos = 0; seen = 0; ox = 0; oy = 0; oz = 0;
      foreach (wt[i]) wt[i] = '0;
      wt[CFG_CENTRE] = CENTRE_RESET;
    endfunction

    function logic [31:0] tap(int unsigned age);
      return line[(wpos + LINE_WORDS - age) % LINE_WORDS];
    endfunction

    function void note_request(logic op, logic [31:0] v);
      logic signed [31:0] nb [7];
      logic signed [67:0] acc;
      logic signed [67:0] r;
      logic [31:0]        c;
      cell_result_t       res;
      wpos = (wpos + 1) % LINE_WORDS;
      line[wpos] = op ? 32'd0 : v;
      if (seen < PLANE_CELLS) begin
        seen++;
        return;
      end
      c = tap(PLANE_CELLS);
      nb[CFG_CENTRE] = c;
      nb[CFG_EAST]   = (ox + 1 >= GRID_X) ? c : tap(PLANE_CELLS - 1);
      nb[CFG_WEST]   = (ox == 0) ? c : tap(PLANE_CELLS + 1);
      nb[CFG_SOUTH]  = (oy + 1 >= GRID_Y) ? c : tap(PLANE_CELLS - GRID_X);
      nb[CFG_NORTH]  = (oy == 0) ? c : tap(PLANE_CELLS + GRID_X);
      nb[CFG_TOP]    = (oz + 1 >= GRID_Z) ? c : tap(0);
      nb[CFG_BOTTOM] = (oz == 0) ? c : tap(2 * PLANE_CELLS);
      acc = '0;
      for (int i = 0; i < 7; i++) acc += longint'(wt[i]) * longint'(nb[i]);
      // Round half up, then clamp to the 32-bit range.
      r = (acc + 68'sd536870912) >>> 30;
      if (r > 68'sd2147483647) r = 68'sd2147483647;
      if (r < -68'sd2147483648) r = -68'sd2147483648;
      res.value = r[31:0];
      res.last  = (ox + 1 >= GRID_X) && (oy + 1 >= GRID_Y) && (oz + 1 >= GRID_Z);
      pending.push_back(res);
      if (res.last) begin
        seen = 0; ox = 0; oy = 0; oz = 0;
      end else begin
        ox++;
        if (ox >= GRID_X) begin
          ox = 0; oy++;
          if (oy >= GRID_Y) begin
            oy = 0; oz++;
          end
        end
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] v, logic l);
      cell_result_t exp_res;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h last=%b", v, l));
        return;
      end
      exp_res = pending.pop_front();
      if (v !== exp_res.value)
        report($sformatf("out_value %h, predicted %h", v, exp_res.value));
      if (l !== exp_res.last)
        report($sformatf("out_last_cell %b, predicted %b", l, exp_res.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [31:0] in_cell_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;
  logic        out_last_cell;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  stencil_scoreboard  sb;
  int                 send_idle_pct;
  int                 stall_pct;
  int                 hold_left;
  int unsigned        cycles;
  int unsigned        requests;
  logic signed [31:0] next_w [7];
  logic [31:0]        extremes [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                       32'h0000_0001};

  diffusion_stencil_3d uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_cell_value(in_cell_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_last_cell(out_last_cell),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels at each edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_op, in_cell_value);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_value, out_last_cell);
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request, idling first at the current sender rate.
  task send_request(logic op, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    requests++;
  endtask

  // Stop sending and let every predicted result arrive.
  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Load the staged weight set into the block and the predictor.
  task write_weights();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= next_w[i];
      sb.wt[i] = next_w[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Weight sets: small, all maximum, all minimum, or any value.
  task stage_weights(int kind);
    for (int i = 0; i < 7; i++) begin
      case (kind % 4)
        0: next_w[i] = $signed($urandom) >>> 3;
        1: next_w[i] = 32'sh7FFF_FFFF;
        2: next_w[i] = 32'sh8000_0000;
        default: next_w[i] = $urandom;
      endcase
    end
  endtask

  function logic [31:0] pick_value();
    if ($urandom_range(9) == 0) return extremes[$urandom_range(4)];
    return $urandom;
  endfunction

  initial begin
    int phase;
    logic op;
    sb = new();
    sb.clear();
    cycles = 0; requests = 0; hold_left = 0;
    send_idle_pct = 0; stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_op = 1'b0; in_cell_value = '0;
    out_stall = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stage_weights(0);
    write_weights();

    // Lead-in plane fills the delay line; every later request yields a result.
    phase = -1;
    for (int k = 0; k < PLANE_CELLS + CHECK_ITEMS; k++) begin
      if (k >= PLANE_CELLS && (k - PLANE_CELLS) % PHASE_LEN == 0) begin
        phase++;
        drain();
        stage_weights(phase);
        write_weights();
        case (phase)
          1: begin send_idle_pct = 68; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 68; hold_left = 400; end
          3: begin send_idle_pct = 17; stall_pct = 17; end
          default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
      end
      if (k < 20) begin
        // Extremes of the value, and two flush requests out of place.
        op = (k == 7 || k == 13);
        send_request(op, extremes[k % 5]);
      end else begin
        send_request($urandom_range(99) < 3, pick_value());
      end
    end
    drain();

    $display("Streamed %0d requests: a lead-in plane, then checked cells in four phases.",
             requests);
    $display("Checked %0d results across several weight sets and idle patterns.", sb.checked);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
